// ===== rtl/core/tapc_pkg.sv =====
// shared types, constants and helpers for the three-axis pid controller
// no dependencies
package tapc_pkg;
	localparam int CmdW = 12;
	localparam int MeasW = 16;
	localparam int DtW = 16;
	localparam int GainW = 16;
	localparam int LimW = 23;
	localparam int DriveW = 16;
	localparam int StW = 24;
	localparam int DivW = 48;

	localparam logic [2:0] RegProp = 3'd0;
	localparam logic [2:0] RegDeriv = 3'd1;
	localparam logic [2:0] RegInteg = 3'd2;
	localparam logic [2:0] RegLimit = 3'd3;
	localparam logic [2:0] RegWeight = 3'd4;
	localparam logic [LimW-1:0] LimitReset = 23'd25600;

	// ceil(2^32 / 169), exact for magnitudes below 2^24
	localparam logic [24:0] RecipTgt = 25'd25414008;
	// ceil(2^41 / 15625), exact for magnitudes below 2^27 (after the divide by 64)
	localparam logic [27:0] RecipUs = 28'd140737489;

	typedef struct packed {
		logic [GainW-1:0] prop;
		logic [GainW-1:0] deriv;
		logic [GainW-1:0] integ;
		logic [LimW-1:0] limit;
		logic [GainW-1:0] weight;
	} cfg_t;

	typedef enum logic [3:0] {
		LS_IDLE, LS_TGT, LS_ERR, LS_DMUL, LS_DDIV, LS_DWAIT, LS_FMUL, LS_FDIV,
		LS_FWAIT, LS_IMUL, LS_IREC, LS_IADD, LS_PROD, LS_SUM, LS_DONE
	} lane_state_t;

	typedef enum logic [1:0] {TS_IDLE, TS_RUN, TS_OUT} top_state_t;

	function automatic logic signed [DriveW-1:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7fff;
		else if (v < -48'sd32768) return 16'sh8000;
		else return v[15:0];
	endfunction

	function automatic logic signed [StW-1:0] clamp_lim(input logic signed [47:0] v,
		input logic [LimW-1:0] lim);
		logic signed [47:0] l;
		l = $signed({25'd0, lim});
		if (v > l) return l[StW-1:0];
		else if (v < -l) return -l[StW-1:0];
		else return v[StW-1:0];
	endfunction

	// divide by 2^20 truncating toward zero
	function automatic logic signed [47:0] div_2p20(input logic signed [47:0] v);
		logic signed [47:0] b;
		b = v + (v[47] ? 48'sd1048575 : 48'sd0);
		return b >>> 20;
	endfunction
endpackage

// ===== rtl/core/tapc_stream_if.sv =====
// valid/ready channel carrying a packed payload
// depends on nothing
interface tapc_stream_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tapc_div.sv =====
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// depends on tapc_pkg
module tapc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [tapc_pkg::DivW-1:0] num,
	input  logic [tapc_pkg::DivW-1:0] den,
	output logic done,
	output logic signed [tapc_pkg::DivW-1:0] quo
);
	localparam int W = tapc_pkg::DivW;
	logic [W-1:0] q_q, d_q;
	logic [W:0] r_q;
	logic neg_q, busy_q;
	logic [5:0] cnt_q;
	logic [W:0] rs;
	logic [W-1:0] mag;

	always_comb begin
		rs = {r_q[W-1:0], q_q[W-1]};
		mag = num[W-1] ? W'(-num) : W'(num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= mag;
			d_q <= den;
			r_q <= '0;
			neg_q <= num[W-1];
		end else if (busy_q) begin
			if (rs >= {1'b0, d_q}) begin
				r_q <= rs - {1'b0, d_q};
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

// ===== rtl/core/tapc_lane.sv =====
// one axis of the pid step: target, error, filtered derivative, integral, products
// depends on tapc_pkg, tapc_div
module tapc_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  tapc_pkg::cfg_t cfg,
	input  logic [tapc_pkg::CmdW-1:0] cmd,
	input  logic signed [tapc_pkg::MeasW-1:0] meas,
	input  logic [tapc_pkg::DtW-1:0] dt,
	output logic done,
	output logic signed [47:0] p_prod,
	output logic signed [47:0] d_prod,
	output logic signed [47:0] i_prod,
	output logic signed [tapc_pkg::DriveW-1:0] drive
);
	tapc_pkg::lane_state_t st_q, st_d;
	logic signed [tapc_pkg::StW-1:0] prev_err_q, prev_der_q, integ_q;
	logic signed [tapc_pkg::StW-1:0] err_q;
	logic signed [tapc_pkg::MeasW-1:0] meas_q;
	logic [tapc_pkg::DtW-1:0] dt_q;
	logic signed [47:0] acc_q, deriv_q;
	logic [54:0] rprod_q;
	logic neg_q;
	logic div_start, div_done;
	logic signed [47:0] div_num, div_quo;
	logic [47:0] div_den;
	logic signed [47:0] tprod;
	logic [47:0] acc_abs;
	logic [23:0] tgt_mag;
	logic [26:0] us_mag;
	logic signed [47:0] tgt_val, int_val;

	tapc_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= tapc_pkg::LS_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		div_start = 1'b0;
		div_num = acc_q;
		div_den = 48'd0;
		done = 1'b0;
		case (st_q)
			tapc_pkg::LS_IDLE: if (start) st_d = tapc_pkg::LS_TGT;
			tapc_pkg::LS_TGT: st_d = tapc_pkg::LS_ERR;
			tapc_pkg::LS_ERR: st_d = tapc_pkg::LS_DMUL;
			tapc_pkg::LS_DMUL: st_d = tapc_pkg::LS_DDIV;
			tapc_pkg::LS_DDIV: begin
				div_start = 1'b1;
				div_den = {32'd0, dt_q};
				st_d = tapc_pkg::LS_DWAIT;
			end
			tapc_pkg::LS_DWAIT: if (div_done) st_d = tapc_pkg::LS_FMUL;
			tapc_pkg::LS_FMUL: st_d = tapc_pkg::LS_FDIV;
			tapc_pkg::LS_FDIV: begin
				div_start = 1'b1;
				div_den = {31'd0, 17'(cfg.weight) + 17'd256};
				st_d = tapc_pkg::LS_FWAIT;
			end
			tapc_pkg::LS_FWAIT: if (div_done) st_d = tapc_pkg::LS_IMUL;
			tapc_pkg::LS_IMUL: st_d = tapc_pkg::LS_IREC;
			tapc_pkg::LS_IREC: st_d = tapc_pkg::LS_IADD;
			tapc_pkg::LS_IADD: st_d = tapc_pkg::LS_PROD;
			tapc_pkg::LS_PROD: st_d = tapc_pkg::LS_SUM;
			tapc_pkg::LS_SUM: st_d = tapc_pkg::LS_DONE;
			tapc_pkg::LS_DONE: begin
				done = 1'b1;
				st_d = tapc_pkg::LS_IDLE;
			end
			default: st_d = tapc_pkg::LS_IDLE;
		endcase
	end

	// pulse offset product, magnitudes for the reciprocal divides, signed quotients
	always_comb begin
		tprod = 48'($signed({1'b0, cmd}) - 14'sd1075) * 48'sd3072;
		acc_abs = acc_q[47] ? -acc_q : acc_q;
		tgt_mag = acc_abs[23:0];
		us_mag = acc_abs[32:6];
		tgt_val = neg_q ? -$signed({31'd0, rprod_q[48:32]}) : $signed({31'd0, rprod_q[48:32]});
		int_val = neg_q ? -$signed({34'd0, rprod_q[54:41]}) : $signed({34'd0, rprod_q[54:41]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			prev_der_q <= '0;
			integ_q <= '0;
		end else begin
			if (st_q == tapc_pkg::LS_FWAIT && div_done)
				prev_der_q <= tapc_pkg::clamp_lim(div_quo, cfg.limit);
			if (st_q == tapc_pkg::LS_IADD) begin
				integ_q <= tapc_pkg::clamp_lim(48'(integ_q) + int_val, cfg.limit);
				prev_err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			tapc_pkg::LS_IDLE: if (start) begin
				acc_q <= tprod;
				meas_q <= meas;
				dt_q <= (dt == 16'd0) ? 16'd1 : dt;
			end
			// divide by 169 as a reciprocal multiply on the magnitude
			tapc_pkg::LS_TGT: begin
				rprod_q <= 55'(tgt_mag) * 55'(tapc_pkg::RecipTgt);
				neg_q <= acc_q[47];
			end
			tapc_pkg::LS_ERR: err_q <= 24'(tgt_val - 48'sd7680 - 48'(meas_q));
			tapc_pkg::LS_DMUL: acc_q <= (48'(err_q) - 48'(prev_err_q)) * 48'sd1000000;
			tapc_pkg::LS_DWAIT: if (div_done) deriv_q <= div_quo;
			tapc_pkg::LS_FMUL: acc_q <= 48'(prev_der_q) * $signed({32'd0, cfg.weight})
				+ (deriv_q <<< 8);
			tapc_pkg::LS_IMUL: acc_q <= 48'(err_q) * $signed({32'd0, dt_q});
			// divide by one million: drop six bits, then reciprocal of 15625
			tapc_pkg::LS_IREC: begin
				rprod_q <= 55'(us_mag) * 55'(tapc_pkg::RecipUs);
				neg_q <= acc_q[47];
			end
			tapc_pkg::LS_PROD: begin
				p_prod <= $signed({32'd0, cfg.prop}) * 48'(err_q);
				d_prod <= $signed({32'd0, cfg.deriv}) * 48'(prev_der_q);
				i_prod <= $signed({32'd0, cfg.integ}) * 48'(integ_q);
			end
			tapc_pkg::LS_SUM: drive <= tapc_pkg::sat16(tapc_pkg::div_2p20(p_prod + d_prod + i_prod));
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> st_q == tapc_pkg::LS_IDLE) else $error("lane done not followed by idle");
	a_lim: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(st_q) == tapc_pkg::LS_SUM) else $error("lane done out of order");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == tapc_pkg::LS_IDLE) else $error("lane started while busy");
`endif
endmodule

// ===== rtl/core/three_axis_pid_controller_top.sv =====
// from input transfer to result valid, the time is set by the two 48-bit
// divisions per lane (by step time and by filter weight), one quotient bit per cycle
// throughput: one item at a time, next input after the result is taken; lanes run in parallel
// reset: arst_n asynchronous, clears state, control and configuration registers to their reset values
// depends on tapc_pkg, tapc_stream_if, tapc_lane
module three_axis_pid_controller_top #(
	parameter int AXES = 3
) (
	input  logic clk,
	input  logic arst_n,
	tapc_stream_if.sink in_ch,
	tapc_stream_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	tapc_pkg::cfg_t cfg_q;
	tapc_pkg::top_state_t st_q;
	logic [AXES-1:0] lane_done;
	logic [AXES-1:0] done_q;
	logic lane_start;
	logic signed [47:0] p_prod [AXES];
	logic signed [47:0] d_prod [AXES];
	logic signed [47:0] i_prod [AXES];
	logic signed [15:0] drv [AXES];
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{prop: '0, deriv: '0, integ: '0, limit: tapc_pkg::LimitReset, weight: '0};
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				tapc_pkg::RegProp: cfg_q.prop <= pwdata[15:0];
				tapc_pkg::RegDeriv: cfg_q.deriv <= pwdata[15:0];
				tapc_pkg::RegInteg: cfg_q.integ <= pwdata[15:0];
				tapc_pkg::RegLimit: cfg_q.limit <= pwdata[22:0];
				tapc_pkg::RegWeight: cfg_q.weight <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tapc_pkg::RegProp: prdata = {16'd0, cfg_q.prop};
			tapc_pkg::RegDeriv: prdata = {16'd0, cfg_q.deriv};
			tapc_pkg::RegInteg: prdata = {16'd0, cfg_q.integ};
			tapc_pkg::RegLimit: prdata = {9'd0, cfg_q.limit};
			tapc_pkg::RegWeight: prdata = {16'd0, cfg_q.weight};
			default: prdata = '0;
		endcase
	end

	// input payload: cmds, then measurements, then step time
	assign in_ch.ready = (st_q == tapc_pkg::TS_IDLE);
	assign lane_start = in_ch.valid && in_ch.ready;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		tapc_lane u_lane (
			.clk, .arst_n, .start(lane_start), .cfg(cfg_q),
			.cmd(in_ch.data[a*12 +: 12]),
			.meas(in_ch.data[AXES*12 + a*16 +: 16]),
			.dt(in_ch.data[AXES*28 +: 16]),
			.done(lane_done[a]),
			.p_prod(p_prod[a]), .d_prod(d_prod[a]), .i_prod(i_prod[a]),
			.drive(drv[a])
		);
	end

	// lanes read the input bus only at their start transfer and later keep copies;
	// the bus is held by the source only until then, so lanes latch what they need
	// merge stage: gather drives and the axis-0 p, d and i terms into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tapc_pkg::TS_IDLE;
			done_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			case (st_q)
				tapc_pkg::TS_IDLE: if (lane_start) st_q <= tapc_pkg::TS_RUN;
				tapc_pkg::TS_RUN: begin
					if (&(done_q | lane_done)) begin
						done_q <= '0;
						out_ch.valid <= 1'b1;
						st_q <= tapc_pkg::TS_OUT;
					end else begin
						done_q <= done_q | lane_done;
					end
				end
				tapc_pkg::TS_OUT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					st_q <= tapc_pkg::TS_IDLE;
				end
				default: st_q <= tapc_pkg::TS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == tapc_pkg::TS_RUN && &(done_q | lane_done)) begin
			for (int a = 0; a < AXES; a++) out_ch.data[a*16 +: 16] <= drv[a];
			out_ch.data[AXES*16 +: 16] <= tapc_pkg::sat16(tapc_pkg::div_2p20(p_prod[0]));
			out_ch.data[AXES*16+16 +: 16] <= tapc_pkg::sat16(tapc_pkg::div_2p20(d_prod[0]));
			out_ch.data[AXES*16+32 +: 16] <= tapc_pkg::sat16(tapc_pkg::div_2p20(i_prod[0]));
		end
	end

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while result waits");
	a_lane_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done != '0 |-> st_q == tapc_pkg::TS_RUN) else $error("lane finished outside run");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
`endif
endmodule
